>>> src/histogram_median_filter_assert.svh
// Assertion macros shared by the checker of the histogram median filter.
// Needs nothing but a clock and an active-low reset in the using module.
`ifndef HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH

// consequent in the same cycle
`define HMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define HMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hmf_pkg.sv
// Package of the histogram median filter: beat types, register indexes,
// controller states and the lane control group. Depends on nothing.
`timescale 1ns / 1ps

package hmf_pkg;

	localparam int NUM_BINS   = 256;
	localparam int BIN_W      = 8;
	localparam int SAMP_W     = 8;
	localparam int NUM_CH     = 4;
	localparam int ROW_W      = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int WREG_W     = 11;
	localparam int HREG_W     = 13;
	localparam int RREG_W     = 3;
	localparam int CREG_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_RADIUS = 1;
	localparam int RST_CHANS  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;

	localparam logic FUNC_PIXEL = 1'b0;

	typedef struct packed {
		logic              func;
		logic [SAMP_W-1:0] sample_0;
		logic [SAMP_W-1:0] sample_1;
		logic [SAMP_W-1:0] sample_2;
		logic [SAMP_W-1:0] sample_3;
	} hmf_in_t;

	typedef struct packed {
		logic [SAMP_W-1:0] median_0;
		logic [SAMP_W-1:0] median_1;
		logic [SAMP_W-1:0] median_2;
		logic [SAMP_W-1:0] median_3;
		logic              image_done;
	} hmf_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WIN_RD,
		ST_WIN_BIN,
		ST_WIN_UPD,
		ST_SCAN,
		ST_FIN
	} hmf_state_t;

	typedef struct packed {
		logic             start;
		logic             clr_wr;
		logic             lookup;
		logic             bump;
		logic             scan_rd;
		logic             scan_acc;
		logic [BIN_W-1:0] bin;
	} hmf_lane_ctl_t;

endpackage

>>> src/hmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the line store and the per-lane histograms. No dependencies.
`timescale 1ns / 1ps

module hmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/hmf_lane.sv
// One channel lane: a 256-bin histogram in RAM, bin increment and the
// cumulative scan that finds the median. Depends on hmf_pkg and hmf_ram.
`timescale 1ns / 1ps

module hmf_lane #(
	parameter int AREA_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hmf_pkg::hmf_lane_ctl_t      ctl,
	input  logic [hmf_pkg::SAMP_W-1:0]  sample,
	input  logic [AREA_W-1:0]           half,
	output logic [hmf_pkg::SAMP_W-1:0]  median
);

	import hmf_pkg::*;

	logic [BIN_W-1:0]  samp_q;
	logic [BIN_W-1:0]  prev_q;
	logic [AREA_W-1:0] cum_q;
	logic              found_q;
	logic [SAMP_W-1:0] med_q;
	logic [AREA_W-1:0] rdata;
	logic [AREA_W-1:0] wdata;
	logic [BIN_W-1:0]  waddr;
	logic [BIN_W-1:0]  raddr;
	logic              we;
	logic [AREA_W:0]   sum;

	assign raddr = ctl.lookup ? sample : ctl.bin;
	assign sum   = {1'b0, cum_q} + {1'b0, rdata};

	always_comb begin
		we    = 1'b0;
		waddr = ctl.bin;
		wdata = '0;
		if (ctl.clr_wr) begin
			we = 1'b1;
		end else if (ctl.bump) begin
			we    = 1'b1;
			waddr = samp_q;
			wdata = rdata + AREA_W'(1);
		end else if (ctl.scan_acc) begin
			we    = 1'b1;
			waddr = prev_q;
		end
	end

	hmf_ram #(
		.WIDTH(AREA_W),
		.DEPTH(NUM_BINS)
	) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.start) begin
			cum_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.scan_acc) begin
			cum_q <= sum[AREA_W-1:0];
			if (!found_q && sum > {1'b0, half}) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			samp_q <= sample;
		end
		if (ctl.scan_rd) begin
			prev_q <= ctl.bin;
		end
		if (ctl.start) begin
			med_q <= '1;
		end else if (ctl.scan_acc && !found_q && sum > {1'b0, half}) begin
			med_q <= prev_q;
		end
	end

	assign median = med_q;

endmodule

>>> src/histogram_median_filter.sv
// Square-window median filter over raster pixels of up to four 8-bit channels.
// Pixel beats enter on pix (valid/stall), filtered pixels leave on med
// (valid/stall), registers are written on cfg (valid/ready, index and data).
// Each accepted pixel beat within the image stores its pixel in the line store,
// and any accepted beat, once the window of the next raster output is complete,
// yields one result beat. For a result, each lane does the histogram
// read-modify-write for every window pixel, then a 256-bin scan of its RAM.
// Lanes run side by side, one per channel; the merge stage zeroes unused
// channels into the output. After reset a pass over all 256 bins zeroes the
// histograms; pix is stalled during it, cfg writes are taken. Reset gives
// width 640, height 480, radius 1 and one channel. A stalled result is held
// in the output register while the next pixel beat is already taken; that
// beat waits only if it yields a result. A write to one of the four
// registers restarts the image; the last pixel carries image_done.
// Depends on hmf_pkg, hmf_lane and hmf_ram.
`timescale 1ns / 1ps

module histogram_median_filter #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_RADIUS   = 7,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  hmf_pkg::hmf_in_t                pix,
	output logic                            med_valid,
	input  logic                            med_stall,
	output hmf_pkg::hmf_out_t               med,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import hmf_pkg::*;

	localparam int COL_W     = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
	localparam int SLOT_W    = $clog2(LINE_ROWS);
	localparam int LS_DEPTH  = LINE_ROWS * MAX_WIDTH;
	localparam int LS_AW     = $clog2(LS_DEPTH);
	localparam int RAD_W     = MAX_RADIUS > 0 ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int SIDE_W    = RAD_W + 1;
	localparam int AREA_W    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
	localparam int YW        = ROW_W + SIDE_W + 2;
	localparam int XW        = WID_W + SIDE_W + 2;
	localparam int RST_W     = RST_WIDTH > MAX_WIDTH ? MAX_WIDTH : RST_WIDTH;
	localparam int RST_R     = RST_RADIUS > MAX_RADIUS ? MAX_RADIUS : RST_RADIUS;
	localparam int RST_C     = RST_CHANS > MAX_CHANNELS ? MAX_CHANNELS : RST_CHANS;

	hmf_state_t state_q, state_d;

	logic [WID_W-1:0]  w_q;
	logic [ROW_W-1:0]  h_q;
	logic [RAD_W-1:0]  r_q;
	logic [CREG_W-1:0] nch_q;

	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [SIDE_W-1:0] i_q, j_q;
	logic              last_q;
	logic [BIN_W:0]    scnt_q;
	logic              med_valid_q;
	hmf_out_t          med_q;

	logic cfg_we, cfg_hit, pix_acc, is_pix, need, load, adv, done;
	hmf_lane_ctl_t lane_ctl;

	logic [WREG_W-1:0] wv;
	logic [HREG_W-1:0] hv;
	logic [RREG_W-1:0] rv;
	logic [CREG_W-1:0] cv;
	logic [WID_W-1:0]  eff_w;
	logic [ROW_W-1:0]  eff_h;
	logic [RAD_W-1:0]  eff_r;
	logic [CREG_W-1:0] eff_c;

	logic [SIDE_W-1:0] side, two_r;
	logic [AREA_W-1:0] area, half;

	logic signed [YW-1:0] y_raw, hm1, y_cl, y_d, y_s;
	logic signed [XW-1:0] x_raw, wm1, x_cl;
	logic [YW-1:0]        ry;
	logic [XW-1:0]        rx;
	logic [SLOT_W-1:0]    rd_slot;
	logic [LS_AW-1:0]     rd_addr, wr_addr;
	logic [31:0]          ls_wdata, ls_rdata;
	logic [SAMP_W-1:0]    lane_med [NUM_CH];
	logic [SAMP_W-1:0]    mrg [NUM_CH];

	// register write, with saturation to the supported range
	assign cfg_ready = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
	assign cfg_we    = cfg_valid && cfg_ready;
	assign wv        = cfg_data[WREG_W-1:0];
	assign hv        = cfg_data[HREG_W-1:0];
	assign rv        = cfg_data[RREG_W-1:0];
	assign cv        = cfg_data[CREG_W-1:0];

	always_comb begin
		if (wv == '0) begin
			eff_w = WID_W'(1);
		end else if (int'(wv) > MAX_WIDTH) begin
			eff_w = WID_W'(MAX_WIDTH);
		end else begin
			eff_w = WID_W'(wv);
		end
		if (hv == '0) begin
			eff_h = ROW_W'(1);
		end else if (int'(hv) > MAX_HEIGHT) begin
			eff_h = ROW_W'(MAX_HEIGHT);
		end else begin
			eff_h = ROW_W'(hv);
		end
		if (int'(rv) > MAX_RADIUS) begin
			eff_r = RAD_W'(MAX_RADIUS);
		end else begin
			eff_r = RAD_W'(rv);
		end
		if (cv == '0) begin
			eff_c = CREG_W'(1);
		end else if (int'(cv) > MAX_CHANNELS) begin
			eff_c = CREG_W'(MAX_CHANNELS);
		end else begin
			eff_c = cv;
		end
	end

	always_comb begin
		unique case (cfg_index)
			REG_IMG_WIDTH, REG_IMG_HEIGHT, REG_RADIUS, REG_CHANNEL_COUNT: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WID_W'(RST_W);
			h_q   <= ROW_W'(RST_HEIGHT);
			r_q   <= RAD_W'(RST_R);
			nch_q <= CREG_W'(RST_C);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMG_WIDTH:     w_q   <= eff_w;
				REG_IMG_HEIGHT:    h_q   <= eff_h;
				REG_RADIUS:        r_q   <= eff_r;
				REG_CHANNEL_COUNT: nch_q <= eff_c;
				default: ;
			endcase
		end
	end

	// window geometry
	assign side  = {r_q, 1'b1};
	assign two_r = {r_q, 1'b0};
	assign area  = AREA_W'(AREA_W'(side) * AREA_W'(side));
	assign half  = area >> 1;

	assign pix_acc = pix_valid && !pix_stall;
	assign is_pix  = (pix.func == FUNC_PIXEL) && (in_row_q < h_q);
	assign done    = (out_row_q == h_q - ROW_W'(1)) && (WID_W'(out_col_q) == w_q - WID_W'(1));

	assign hm1 = YW'(h_q) - YW'(1);
	assign wm1 = XW'(w_q) - XW'(1);

	always_comb begin
		ry = YW'(out_row_q) + YW'(r_q);
		if (ry > YW'(hm1)) begin
			ry = YW'(hm1);
		end
		rx = XW'(out_col_q) + XW'(r_q);
		if (rx > XW'(wm1)) begin
			rx = XW'(wm1);
		end
		need = (YW'(in_row_q) > ry) || ((YW'(in_row_q) == ry) && (XW'(in_col_q) > rx));
	end

	// clamped window coordinates and line-store slot of the current tap
	always_comb begin
		y_raw = YW'(out_row_q) + YW'(i_q) - YW'(r_q);
		if (y_raw < 0) begin
			y_cl = '0;
		end else if (y_raw > hm1) begin
			y_cl = hm1;
		end else begin
			y_cl = y_raw;
		end
		y_d = y_cl - YW'(out_row_q);
		y_s = YW'(out_slot_q) + y_d;
		if (y_s < 0) begin
			y_s = y_s + YW'(LINE_ROWS);
		end else if (y_s >= YW'(LINE_ROWS)) begin
			y_s = y_s - YW'(LINE_ROWS);
		end
		rd_slot = y_s[SLOT_W-1:0];
		x_raw = XW'(out_col_q) + XW'(j_q) - XW'(r_q);
		if (x_raw < 0) begin
			x_cl = '0;
		end else if (x_raw > wm1) begin
			x_cl = wm1;
		end else begin
			x_cl = x_raw;
		end
		rd_addr = LS_AW'(rd_slot * MAX_WIDTH + x_cl[COL_W-1:0]);
		wr_addr = LS_AW'(in_slot_q * MAX_WIDTH + in_col_q);
	end

	assign ls_wdata = {pix.sample_3, pix.sample_2, pix.sample_1, pix.sample_0};

	hmf_ram #(
		.WIDTH(32),
		.DEPTH(LS_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (pix_acc && is_pix),
		.waddr (wr_addr),
		.wdata (ls_wdata),
		.raddr (rd_addr),
		.rdata (ls_rdata)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		pix_stall        = 1'b1;
		load             = 1'b0;
		adv              = 1'b0;
		lane_ctl         = '0;
		lane_ctl.bin     = scnt_q[BIN_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				lane_ctl.clr_wr = 1'b1;
				if (scnt_q[BIN_W-1:0] == BIN_W'(NUM_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				pix_stall = cfg_valid;
				if (pix_valid && !cfg_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (need) begin
					lane_ctl.start = 1'b1;
					state_d        = ST_WIN_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WIN_RD: begin
				adv     = 1'b1;
				state_d = ST_WIN_BIN;
			end
			ST_WIN_BIN: begin
				lane_ctl.lookup = 1'b1;
				state_d         = ST_WIN_UPD;
			end
			ST_WIN_UPD: begin
				lane_ctl.bump = 1'b1;
				if (last_q) begin
					state_d = ST_SCAN;
				end else begin
					adv     = 1'b1;
					state_d = ST_WIN_BIN;
				end
			end
			ST_SCAN: begin
				lane_ctl.scan_rd  = !scnt_q[BIN_W];
				lane_ctl.scan_acc = (scnt_q != '0);
				if (scnt_q[BIN_W]) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!med_valid_q || !med_stall) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			last_q <= 1'b0;
			scnt_q <= '0;
		end else begin
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				scnt_q <= scnt_q + (BIN_W + 1)'(1);
			end else begin
				scnt_q <= '0;
			end
			if (state_q == ST_CHECK) begin
				i_q    <= '0;
				j_q    <= '0;
				last_q <= 1'b0;
			end else if (adv) begin
				if (j_q == two_r) begin
					j_q <= '0;
					if (i_q == two_r) begin
						last_q <= 1'b1;
					end else begin
						i_q <= i_q + SIDE_W'(1);
					end
				end else begin
					j_q <= j_q + SIDE_W'(1);
				end
			end
		end
	end

	// raster positions of the next input and next output pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
		end else if ((cfg_we && cfg_hit) || (load && done)) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
		end else begin
			if (pix_acc && is_pix) begin
				if (XW'(in_col_q) + XW'(1) >= XW'(w_q)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
					in_slot_q <= (in_slot_q == SLOT_W'(LINE_ROWS - 1)) ? '0
						: in_slot_q + SLOT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (load) begin
				if (XW'(out_col_q) + XW'(1) >= XW'(w_q)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
					out_slot_q <= (out_slot_q == SLOT_W'(LINE_ROWS - 1)) ? '0
						: out_slot_q + SLOT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// channel lanes
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		if (ch < MAX_CHANNELS) begin : g_on
			hmf_lane #(
				.AREA_W(AREA_W)
			) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (lane_ctl),
				.sample (ls_rdata[SAMP_W*ch +: SAMP_W]),
				.half   (half),
				.median (lane_med[ch])
			);
		end else begin : g_off
			assign lane_med[ch] = '0;
		end
	end

	// merge: drop unused channels
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			mrg[ch] = (CREG_W'(ch) < nch_q) ? lane_med[ch] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_valid_q <= 1'b0;
		end else if (load) begin
			med_valid_q <= 1'b1;
		end else if (!med_stall) begin
			med_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			med_q.median_0   <= mrg[0];
			med_q.median_1   <= mrg[1];
			med_q.median_2   <= mrg[2];
			med_q.median_3   <= mrg[3];
			med_q.image_done <= done;
		end
	end

	assign med_valid = med_valid_q;
	assign med       = med_q;

endmodule

>>> src/hmf_check.sv
// Port-level checker of the histogram median filter, bound to the top level.
// Depends on hmf_pkg and histogram_median_filter_assert.svh.
`timescale 1ns / 1ps
`include "histogram_median_filter_assert.svh"

module hmf_check (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input logic              med_valid,
	input logic              med_stall,
	input hmf_pkg::hmf_out_t med,
	input logic              cfg_ready
);

	`HMF_ASSERT_NEXT(a_med_hold, clk, arst_n, med_valid && med_stall, med_valid, "result beat dropped while stalled")
	`HMF_ASSERT_NEXT(a_med_stable, clk, arst_n, med_valid && med_stall, $stable(med), "stalled result changed")
	`HMF_ASSERT_NEXT(a_pix_busy, clk, arst_n, pix_valid && !pix_stall, pix_stall && !cfg_ready, "pixel beat not held off during processing")
	`HMF_ASSERT_SAME(a_med_rise, clk, arst_n, $rose(med_valid), $past(pix_stall), "result appeared while pixel port was open")

endmodule

bind histogram_median_filter hmf_check u_check (.*);

>>> dv/tb_histogram_median_filter.sv
// Testbench of the histogram median filter: directed table then random images,
// every result beat checked against the table's expected value or an in-bench median predictor.
// Depends on hmf_pkg and histogram_median_filter.
`timescale 1ns / 1ps

module tb_histogram_median_filter;
	import hmf_pkg::*;

	localparam logic FUNC_FLUSH = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam int LINE_ROWS = 16;
	localparam int LINE_W = 1024;
	localparam int RANDOM_BEATS = 1800;

	typedef enum logic [1:0] {ROW_CFG, ROW_BEAT} row_kind_e;

	typedef struct {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		hmf_in_t                beat;
		bit                     typed;
		bit                     yields;
		hmf_out_t               want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	hmf_in_t pix;
	logic med_valid;
	logic med_stall;
	hmf_out_t med;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit [31:0] pixel_lines [0:LINE_ROWS*LINE_W-1];
	bit [WREG_W-1:0] width_reg;
	bit [HREG_W-1:0] height_reg;
	bit [RREG_W-1:0] radius_reg;
	bit [CREG_W-1:0] chans_reg;
	int in_row, in_col, out_row, out_col;

	hmf_out_t pending_medians [$];
	dir_row_t dir_rows [$];
	int errors;
	int idle_pct, stall_pct;
	int beats_sent;

	histogram_median_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.med_valid(med_valid), .med_stall(med_stall), .med(med),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("[histogram_median_filter] ERROR");
		$finish;
	end

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		return (width_reg > LINE_W) ? LINE_W : int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == 0) return 1;
		return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
	endfunction

	function automatic int eff_chans();
		if (chans_reg == 0) return 1;
		return (chans_reg > NUM_CH) ? NUM_CH : int'(chans_reg);
	endfunction

	function automatic void restart_image();
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_IMG_WIDTH: width_reg = d[WREG_W-1:0];
			REG_IMG_HEIGHT: height_reg = d[HREG_W-1:0];
			REG_RADIUS: radius_reg = d[RREG_W-1:0];
			REG_CHANNEL_COUNT: chans_reg = d[CREG_W-1:0];
			default: return;
		endcase
		restart_image();
	endfunction

	function automatic logic [7:0] window_median(int ch, int w, int h, int rad);
		int hist [NUM_BINS];
		int y, x, cum, half;
		for (int v = 0; v < NUM_BINS; v++) hist[v] = 0;
		for (int dy = -rad; dy <= rad; dy++) begin
			y = out_row + dy;
			if (y < 0) y = 0;
			if (y > h - 1) y = h - 1;
			for (int dx = -rad; dx <= rad; dx++) begin
				x = out_col + dx;
				if (x < 0) x = 0;
				if (x > w - 1) x = w - 1;
				hist[pixel_lines[(y % LINE_ROWS) * LINE_W + x][8*ch +: 8]]++;
			end
		end
		half = ((2*rad + 1) * (2*rad + 1)) / 2;
		cum = 0;
		for (int v = 0; v < NUM_BINS; v++) begin
			cum += hist[v];
			if (cum > half) return v[7:0];
		end
		return 8'hFF;
	endfunction

	function automatic bit filter_step(hmf_in_t b, output hmf_out_t r);
		int w, h, rad, nch, ry, rx;
		logic [7:0] m [NUM_CH];
		bit last;
		w = eff_width();
		h = eff_height();
		rad = radius_reg;
		nch = eff_chans();
		r = '0;
		if (b.func == FUNC_PIXEL && in_row < h) begin
			pixel_lines[(in_row % LINE_ROWS) * LINE_W + in_col] =
				{b.sample_3, b.sample_2, b.sample_1, b.sample_0};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		ry = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
		rx = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
		if (longint'(in_row) * w + in_col <= longint'(ry) * w + rx) return 0;
		for (int ch = 0; ch < NUM_CH; ch++)
			m[ch] = (ch < nch) ? window_median(ch, w, h, rad) : 8'h00;
		last = (out_row == h - 1) && (out_col == w - 1);
		r.median_0 = m[0];
		r.median_1 = m[1];
		r.median_2 = m[2];
		r.median_3 = m[3];
		r.image_done = last;
		if (last) begin
			restart_image();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		return 1;
	endfunction

	function automatic void report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		hmf_out_t w;
		if (arst_n && med_valid && !med_stall) begin
			if (pending_medians.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, med);
				errors++;
			end else begin
				w = pending_medians.pop_front();
				report_field("median_0", w.median_0, med.median_0);
				report_field("median_1", w.median_1, med.median_1);
				report_field("median_2", w.median_2, med.median_2);
				report_field("median_3", w.median_3, med.median_3);
				report_field("image_done", w.image_done, med.image_done);
			end
		end
		med_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_beat(hmf_in_t b, bit typed, bit yields, hmf_out_t want);
		hmf_out_t r;
		bit got;
		while ($urandom_range(99) < idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix <= b;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		got = filter_step(b, r);
		beats_sent++;
		if (typed) begin
			if (got != yields) begin
				$display("%0t table row: expected result %0d actual %0d", $time, yields, got);
				errors++;
			end
			if (yields) pending_medians.push_back(want);
		end else if (got) begin
			pending_medians.push_back(r);
		end
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, d);
	endtask

	function automatic hmf_in_t make_beat(logic f, logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [7:0] d);
		hmf_in_t t;
		t.func = f;
		t.sample_0 = a;
		t.sample_1 = b;
		t.sample_2 = c;
		t.sample_3 = d;
		return t;
	endfunction

	function automatic hmf_in_t rand_beat(logic f);
		return make_beat(f, 8'($urandom()), 8'($urandom()), 8'($urandom()),
			8'($urandom()));
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		dir_row_t row;
		row = '{ROW_CFG, idx, d, '0, 0, 0, '0};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_beat(hmf_in_t b, bit typed, bit yields, hmf_out_t want);
		dir_row_t row;
		row = '{ROW_BEAT, '0, '0, b, typed, yields, want};
		dir_rows.push_back(row);
	endfunction

	function automatic hmf_out_t echo(hmf_in_t b, bit last);
		return '{b.sample_0, b.sample_1, b.sample_2, b.sample_3, last};
	endfunction

	task automatic random_image();
		int w, h, n, shown;
		hmf_in_t b;
		drain();
		case ($urandom_range(19))
			0: write_reg(REG_IMG_WIDTH, 13'd0);
			1: write_reg(REG_IMG_WIDTH, 13'd1024);
			2: write_reg(REG_IMG_WIDTH, 13'd2047);
			default: write_reg(REG_IMG_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
		endcase
		case ($urandom_range(19))
			0: write_reg(REG_IMG_HEIGHT, 13'd0);
			1: write_reg(REG_IMG_HEIGHT, 13'd4096);
			2: write_reg(REG_IMG_HEIGHT, 13'd8191);
			default: write_reg(REG_IMG_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
		endcase
		write_reg(REG_RADIUS, CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(0, 7)
			: $urandom_range(0, 2)));
		write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
		if ($urandom_range(9) == 0)
			write_reg(CFG_IDX_W'($urandom_range(4, 7)), CFG_DATA_W'($urandom()));
		w = eff_width();
		h = eff_height();
		n = w * h;
		if (n > 60) n = 40;
		shown = 0;
		while (shown < n) begin
			if ($urandom_range(19) == 0) begin
				b = rand_beat(FUNC_FLUSH);
			end else begin
				b = rand_beat(FUNC_PIXEL);
				shown++;
			end
			send_beat(b, 0, 0, '0);
		end
		if (n == w * h) begin
			while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0) begin
				b = rand_beat(1'($urandom_range(1)));
				send_beat(b, 0, 0, '0);
			end
		end
	endtask

	initial begin
		hmf_in_t p0, p1, p2, p3;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		med_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		width_reg = WREG_W'(RST_WIDTH);
		height_reg = HREG_W'(RST_HEIGHT);
		radius_reg = RREG_W'(RST_RADIUS);
		chans_reg = CREG_W'(RST_CHANS);
		restart_image();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		p0 = make_beat(FUNC_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
		p1 = make_beat(FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00);
		p2 = make_beat(FUNC_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78);
		p3 = make_beat(FUNC_PIXEL, 8'hAB, 8'hCD, 8'hEF, 8'h01);
		// reset setting: first pixel of a 640-wide image gives nothing yet
		add_beat(p1, 1, 0, '0);
		add_cfg(REG_IMG_WIDTH, 13'd2);
		add_cfg(REG_IMG_HEIGHT, 13'd2);
		add_cfg(REG_RADIUS, 13'd0);
		add_cfg(REG_CHANNEL_COUNT, 13'd4);
		add_beat(p0, 1, 1, echo(p0, 0));
		add_beat(p1, 1, 1, echo(p1, 0));
		add_beat(make_beat(FUNC_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00), 1, 0, '0);
		add_beat(p2, 1, 1, echo(p2, 0));
		add_beat(p3, 1, 1, echo(p3, 1));
		add_cfg(REG_IMG_WIDTH, 13'd0);
		add_cfg(REG_IMG_HEIGHT, 13'd0);
		add_cfg(REG_RADIUS, 13'd7);
		add_cfg(REG_CHANNEL_COUNT, 13'd0);
		add_cfg(REG_SPARE, 13'h1FFF);
		add_beat(p1, 1, 1, '{8'hFF, 8'h00, 8'h00, 8'h00, 1'b1});
		add_cfg(REG_IMG_WIDTH, 13'd3);
		add_cfg(REG_IMG_HEIGHT, 13'd3);
		add_cfg(REG_RADIUS, 13'd1);
		add_cfg(REG_CHANNEL_COUNT, 13'd7);
		for (int i = 0; i < 9; i++)
			add_beat((i % 2) ? p0 : ((i % 3) ? p3 : p1), 0, 0, '0);
		// the next pixels arrive with the image full and are not stored; they and the flush ticks drain the remaining results
		add_beat(p2, 0, 0, '0);
		add_beat(p3, 0, 0, '0);
		add_beat(make_beat(FUNC_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, 0, '0);
		add_beat(make_beat(FUNC_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0, '0);
		add_beat(make_beat(FUNC_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0, '0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].yields,
					dir_rows[i].want);
			end
		end

		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			case (beats_sent * 4 / RANDOM_BEATS)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 74; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 74; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			random_image();
		end

		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		if (errors == 0) begin
			$display("[histogram_median_filter] OK");
		end else begin
			$display("[histogram_median_filter] ERROR");
		end
		$finish;
	end

endmodule
